@@ hdl/mlba_pkg.sv @@
// ----------------------------------------------------------------------------
// mlba_pkg
// Shared widths, register indexes and control types of the multilook block
// average core.
// ----------------------------------------------------------------------------
package mlba_pkg;

  // fixed field widths
  localparam int ACC_W      = 44;
  localparam int RES_W      = 28;
  localparam int CNT_W      = 13;
  localparam int ROOT_W     = 23;
  localparam int LW_REG_W   = 13;
  localparam int LOOK_REG_W = 7;
  localparam int ADDR_W     = 5;
  localparam int OUT_W      = 72;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_LINE_WIDTH     = 3'd0;
  localparam logic [2:0] REG_RANGE_LOOKS    = 3'd1;
  localparam logic [2:0] REG_AZIMUTH_LOOKS  = 3'd2;
  localparam logic [2:0] REG_COMPLEX_MODE   = 3'd3;
  localparam logic [2:0] REG_POWER_SUM      = 3'd4;
  localparam logic [2:0] REG_AVERAGE_ENABLE = 3'd5;

  // finishing operation applied to a window sum
  typedef enum logic [1:0] {
    FIN_DIRECT,
    FIN_DIV,
    FIN_ROOT
  } fin_mode_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic fin_start;
    logic fin_sel;
    logic load_out;
  } mlba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic window_done;
    logic cplx;
    logic fin_done;
    logic out_free;
  } mlba_status_t;

endpackage

@@ hdl/mlba_fin.sv @@
// ----------------------------------------------------------------------------
// mlba_fin
// Iterative finishing unit: plain pass, rounded division by nonzero count
// (one quotient bit a cycle) or rounded square root (one root bit a cycle).
// ----------------------------------------------------------------------------
module mlba_fin (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  mlba_pkg::fin_mode_t           mode,
  input  logic [mlba_pkg::ACC_W-1:0]    acc,
  input  logic [mlba_pkg::CNT_W-1:0]    n,
  output logic                          busy,
  output logic                          done,
  output logic [mlba_pkg::RES_W-1:0]    res
);
  import mlba_pkg::*;

  typedef enum logic [1:0] {
    P_IDLE,
    P_DIRECT,
    P_DIV,
    P_ROOT
  } phase_t;

  phase_t                phase;
  logic [ACC_W+1:0]      num;
  logic [CNT_W:0]        dv;
  logic [CNT_W:0]        rem;
  logic [ACC_W+1:0]      quo;
  logic                  neg;
  logic [5:0]            step;
  logic [ROOT_W-1:0]     root;
  logic signed [63:0]    dsq;
  logic signed [63:0]    du;
  logic signed [63:0]    dd;
  logic [ACC_W+1:0]      s4;

  logic [ACC_W-1:0]      mag;
  logic [ACC_W+1:0]      num0;
  logic [CNT_W+1:0]      rs;
  logic                  ge;
  logic [CNT_W+1:0]      rs_sub;
  logic [ACC_W+1:0]      qn;
  logic [4:0]            sh;
  logic signed [63:0]    dsq_c;
  logic signed [63:0]    du_c;
  logic                  fits;
  logic [ROOT_W-1:0]     root_n;

  // start operands
  assign mag  = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
  assign num0 = {1'b0, mag, 1'b0} + (ACC_W+2)'(n);

  // restoring divide step
  assign rs     = {rem, num[ACC_W+1]};
  assign ge     = rs >= {1'b0, dv};
  assign rs_sub = rs - {1'b0, dv};
  assign qn     = {quo[ACC_W:0], ge};

  // root step: try the next bit, update d*u^2 and d*u with shifts only
  assign sh     = step[4:0];
  assign dsq_c  = dsq + (du <<< ({1'b0, sh} + 6'd2)) + (dd <<< ({sh, 1'b0} + 6'd2));
  assign du_c   = du + (dd <<< ({1'b0, sh} + 6'd1));
  assign fits   = dsq_c <= signed'(64'(s4));
  assign root_n = fits ? (root | (ROOT_W'(1) << sh)) : root;

  assign busy = (phase != P_IDLE);

  // sequence the operation
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            case (mode)
              FIN_DIV: begin
                num   <= num0;
                dv    <= {n, 1'b0};
                rem   <= '0;
                quo   <= '0;
                neg   <= acc[ACC_W-1];
                step  <= 6'd45;
                phase <= P_DIV;
              end
              FIN_ROOT: begin
                s4    <= {acc, 2'b00};
                dd    <= signed'(64'(n));
                dsq   <= signed'(64'(n));
                du    <= -signed'(64'(n));
                root  <= '0;
                step  <= 6'(ROOT_W - 1);
                phase <= P_ROOT;
              end
              default: begin
                res   <= acc[RES_W-1:0];
                phase <= P_DIRECT;
              end
            endcase
          end
        end
        P_DIRECT: begin
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        P_DIV: begin
          rem <= ge ? rs_sub[CNT_W:0] : rs[CNT_W:0];
          quo <= qn;
          num <= {num[ACC_W:0], 1'b0};
          if (step == 6'd0) begin
            res   <= neg ? (~qn[RES_W-1:0] + RES_W'(1)) : qn[RES_W-1:0];
            done  <= 1'b1;
            phase <= P_IDLE;
          end else begin
            step <= step - 6'd1;
          end
        end
        P_ROOT: begin
          root <= root_n;
          if (fits) begin
            dsq <= dsq_c;
            du  <= du_c;
          end
          if (step == 6'd0) begin
            res   <= RES_W'(root_n);
            done  <= 1'b1;
            phase <= P_IDLE;
          end else begin
            step <= step - 6'd1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("finish unit started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("finish unit busy after done");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("finish unit went busy without start");
`endif

endmodule

@@ hdl/mlba_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlba_ctrl
// Controller: accepts one sample, sequences the accumulator update, the
// finishing passes and the result hand-off.
// ----------------------------------------------------------------------------
module mlba_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  mlba_pkg::mlba_status_t status,
  output mlba_pkg::mlba_cmd_t    cmd
);
  import mlba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_LAUNCH,
    S_FIN1,
    S_FIN2,
    S_OUT
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);

  // decode commands
  always_comb begin
    cmd.accept    = (state == S_IDLE) && s_tvalid;
    cmd.update    = (state == S_UPD);
    cmd.fin_start = (state == S_LAUNCH) ||
                    ((state == S_FIN1) && status.fin_done && status.cplx);
    cmd.fin_sel   = (state == S_FIN1);
    cmd.load_out  = (state == S_OUT) && status.out_free;
  end

  // advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_UPD;
        end
        S_UPD: begin
          state <= status.window_done ? S_LAUNCH : S_IDLE;
        end
        S_LAUNCH: begin
          state <= S_FIN1;
        end
        S_FIN1: begin
          if (status.fin_done) state <= status.cplx ? S_FIN2 : S_OUT;
        end
        S_FIN2: begin
          if (status.fin_done) state <= S_OUT;
        end
        S_OUT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat taken while item in work");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (state == S_IDLE))
    else $error("controller did not return after result load");
  a_launch: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && status.window_done) |=> cmd.fin_start)
    else $error("completed window not finished");
`endif

endmodule

@@ hdl/mlba_dp.sv @@
// ----------------------------------------------------------------------------
// mlba_dp
// Datapath: raster position counters, per-column accumulator memory, the
// finishing unit and the output register.
// ----------------------------------------------------------------------------
module mlba_dp #(
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int MAX_LOOKS      = 64,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   clear,
  input  mlba_pkg::mlba_cmd_t                    cmd,
  output mlba_pkg::mlba_status_t                 status,
  input  logic [$clog2(MAX_LINE_WIDTH+1)-1:0]    lw,
  input  logic [$clog2(MAX_LOOKS+1)-1:0]         rl,
  input  logic [$clog2(MAX_LOOKS+1)-1:0]         al,
  input  logic                                   complex_mode,
  input  logic                                   power_sum,
  input  logic                                   average_enable,
  input  logic signed [SAMPLE_BITS-1:0]          sample_first,
  input  logic signed [SAMPLE_BITS-1:0]          sample_second,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [mlba_pkg::OUT_W-1:0]             m_tdata,
  output logic                                   m_tlast
);
  import mlba_pkg::*;

  localparam int AW     = $clog2(MAX_LINE_WIDTH);
  localparam int PH_W   = (MAX_LOOKS > 1) ? $clog2(MAX_LOOKS) : 1;
  localparam int WORD_W = 2 * ACC_W + CNT_W;
  localparam int PAD_W  = OUT_W - 2 * RES_W - CNT_W;

  logic [AW-1:0]   col;
  logic [AW-1:0]   oc;
  logic [AW-1:0]   base;
  logic [PH_W-1:0] rp;
  logic [PH_W-1:0] ap;

  logic [WORD_W-1:0] mem [MAX_LINE_WIDTH];
  logic [WORD_W-1:0] rdata;

  logic signed [SAMPLE_BITS-1:0] sa;
  logic signed [SAMPLE_BITS-1:0] sb;
  logic [AW-1:0]                 addr_l;
  logic                          fresh_l;
  logic                          in_win_l;
  logic                          emit_l;
  logic                          row_end_l;

  logic [ACC_W-1:0] sum_a;
  logic [ACC_W-1:0] sum_b;
  logic [CNT_W-1:0] n_l;
  logic             fin_sel_r;
  logic [RES_W-1:0] res_a;
  logic [RES_W-1:0] res_b;

  logic                            line_end;
  logic                            rp_wrap;
  logic                            ap_wrap;
  logic signed [2*SAMPLE_BITS-1:0] sqa;
  logic signed [2*SAMPLE_BITS-1:0] sqb;
  logic signed [63:0]              wa;
  logic signed [63:0]              wb;
  logic                            nz;
  logic [ACC_W-1:0]                old_a;
  logic [ACC_W-1:0]                old_b;
  logic [CNT_W-1:0]                old_n;
  logic [ACC_W-1:0]                new_a;
  logic [ACC_W-1:0]                new_b;
  logic [CNT_W-1:0]                new_n;

  fin_mode_t        fin_mode;
  logic [CNT_W-1:0] fin_n;
  logic             fin_busy;
  logic             fin_done;
  logic [RES_W-1:0] fin_res;

  // position flags
  assign line_end = 32'(col) + 32'd1 >= 32'(lw);
  assign rp_wrap  = 32'(rp) + 32'd1 >= 32'(rl);
  assign ap_wrap  = 32'(ap) + 32'd1 >= 32'(al);

  // advance raster position
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col  <= '0;
      oc   <= '0;
      base <= '0;
      rp   <= '0;
      ap   <= '0;
    end else if (cmd.accept) begin
      if (line_end) begin
        col  <= '0;
        oc   <= '0;
        base <= '0;
        rp   <= '0;
        ap   <= ap_wrap ? '0 : ap + 1'b1;
      end else begin
        col <= col + 1'b1;
        if (rp_wrap) begin
          rp   <= '0;
          oc   <= oc + 1'b1;
          base <= base + AW'(rl);
        end else begin
          rp <= rp + 1'b1;
        end
      end
    end
  end

  // latch the beat and read its column
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sa        <= sample_first;
      sb        <= complex_mode ? sample_second : '0;
      addr_l    <= oc;
      fresh_l   <= (rp == '0) && (ap == '0);
      in_win_l  <= 32'(base) + 32'(rl) <= 32'(lw);
      emit_l    <= rp_wrap && ap_wrap;
      row_end_l <= 32'(base) + 32'd2 * 32'(rl) > 32'(lw);
      rdata     <= mem[oc];
    end
  end

  // add the sample to the column sums; a fresh window starts from zero
  assign sqa   = sa * sa;
  assign sqb   = sb * sb;
  assign wa    = power_sum ? 64'(sqa) : 64'(sa);
  assign wb    = power_sum ? 64'(sqb) : 64'(sb);
  assign nz    = (sa != '0) || (sb != '0);
  assign old_a = fresh_l ? '0 : rdata[ACC_W-1:0];
  assign old_b = fresh_l ? '0 : rdata[2*ACC_W-1:ACC_W];
  assign old_n = fresh_l ? '0 : rdata[WORD_W-1:2*ACC_W];
  assign new_a = nz ? old_a + wa[ACC_W-1:0] : old_a;
  assign new_b = nz ? old_b + wb[ACC_W-1:0] : old_b;
  assign new_n = nz ? old_n + CNT_W'(1) : old_n;

  // write back partial sums, zero samples too so a fresh window is cleared
  always_ff @(posedge clk) begin
    if (cmd.update && in_win_l && !emit_l) begin
      mem[addr_l] <= {new_n, new_b, new_a};
    end
  end

  // hold the completed window sums
  always_ff @(posedge clk) begin
    if (cmd.update && in_win_l && emit_l) begin
      sum_a <= new_a;
      sum_b <= new_b;
      n_l   <= new_n;
    end
  end

  // select the finishing operation
  always_comb begin
    if (power_sum) begin
      fin_mode = FIN_ROOT;
      fin_n    = (average_enable && n_l != '0) ? n_l : CNT_W'(1);
    end else if (average_enable && n_l != '0) begin
      fin_mode = FIN_DIV;
      fin_n    = n_l;
    end else begin
      fin_mode = FIN_DIRECT;
      fin_n    = n_l;
    end
  end

  mlba_fin u_fin (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.fin_start),
    .mode  (fin_mode),
    .acc   (cmd.fin_sel ? sum_b : sum_a),
    .n     (fin_n),
    .busy  (fin_busy),
    .done  (fin_done),
    .res   (fin_res)
  );

  // capture channel results
  always_ff @(posedge clk) begin
    if (cmd.fin_start) fin_sel_r <= cmd.fin_sel;
    if (fin_done) begin
      if (fin_sel_r) res_b <= fin_res;
      else           res_a <= fin_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {{PAD_W{1'b0}}, n_l, (complex_mode ? res_b : RES_W'(0)), res_a};
      m_tlast <= row_end_l;
    end
  end

  assign status.window_done = in_win_l && emit_l;
  assign status.cplx        = complex_mode;
  assign status.fin_done    = fin_done;
  assign status.out_free    = !m_tvalid || m_tready;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !cmd.load_out)
    else $error("result overwritten while stalled");
  a_fin_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !fin_busy)
    else $error("beat taken while finish unit busy");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    32'(base) <= 32'(col))
    else $error("window base past column");
`endif

endmodule

@@ hdl/multilook_block_average_core.sv @@
// ----------------------------------------------------------------------------
// multilook_block_average_core
// Boxcar multilook of a raster sample stream with optional power sum,
// square root and averaging by nonzero count.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on s_* in raster order, line_width per line; s_tdata holds
//   sample_first (low) and sample_second. One result leaves on m_* when a
//   range_looks by azimuth_looks window completes; m_tlast marks the last
//   result of an output line. Registers are written on the APB port only
//   while the block is idle; the user must keep to this, the block does not
//   enforce it. Any write to a listed register restarts the raster.
// Operation:
//   One sample is in work at a time. A completing sample goes through the
//   accumulator update, a finish pass per channel (a plain sum passes
//   through, an average takes one quotient bit a cycle, a root one root bit
//   a cycle) and the result load; complex mode runs the finish unit twice.
//   The accumulator memory is read once and written at most once per sample.
// Reset and stalls:
//   Reset restores register defaults and clears the position counters; the
//   accumulator memory needs no clearing pass, since a window's first sample
//   starts from zero. While m_tready is low the result holds and the block
//   stops taking samples once its next result is ready.
// ----------------------------------------------------------------------------
module multilook_block_average_core #(
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int MAX_LOOKS      = 64,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // s_tdata: sample_first, sample_second, zero pad
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
  // m_tdata: result_first, result_second, nonzero_count, zero pad
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [mlba_pkg::OUT_W-1:0]            m_tdata,
  output logic                                  m_tlast,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mlba_pkg::ADDR_W-1:0]           paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import mlba_pkg::*;

  localparam int CW   = $clog2(MAX_LINE_WIDTH + 1);
  localparam int LK_W = $clog2(MAX_LOOKS + 1);

  logic [LW_REG_W-1:0]   line_width;
  logic [LOOK_REG_W-1:0] range_looks;
  logic [LOOK_REG_W-1:0] azimuth_looks;
  logic                  complex_mode;
  logic                  power_sum;
  logic                  average_enable;

  logic                  wr;
  logic                  clear;
  logic [2:0]            idx;
  logic [CW-1:0]         lw;
  logic [LK_W-1:0]       rl;
  logic [LK_W-1:0]       al;
  mlba_cmd_t             cmd;
  mlba_status_t          status;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;
  assign clear  = wr && (idx == REG_LINE_WIDTH || idx == REG_RANGE_LOOKS ||
                         idx == REG_AZIMUTH_LOOKS || idx == REG_COMPLEX_MODE ||
                         idx == REG_POWER_SUM || idx == REG_AVERAGE_ENABLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width     <= LW_REG_W'(4096);
      range_looks    <= LOOK_REG_W'(4);
      azimuth_looks  <= LOOK_REG_W'(4);
      complex_mode   <= 1'b0;
      power_sum      <= 1'b0;
      average_enable <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_LINE_WIDTH:     line_width     <= pwdata[LW_REG_W-1:0];
        REG_RANGE_LOOKS:    range_looks    <= pwdata[LOOK_REG_W-1:0];
        REG_AZIMUTH_LOOKS:  azimuth_looks  <= pwdata[LOOK_REG_W-1:0];
        REG_COMPLEX_MODE:   complex_mode   <= pwdata[0];
        REG_POWER_SUM:      power_sum      <= pwdata[0];
        REG_AVERAGE_ENABLE: average_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (idx)
      REG_LINE_WIDTH:     prdata = 32'(line_width);
      REG_RANGE_LOOKS:    prdata = 32'(range_looks);
      REG_AZIMUTH_LOOKS:  prdata = 32'(azimuth_looks);
      REG_COMPLEX_MODE:   prdata = 32'(complex_mode);
      REG_POWER_SUM:      prdata = 32'(power_sum);
      REG_AVERAGE_ENABLE: prdata = 32'(average_enable);
      default:            prdata = '0;
    endcase
  end

  // clamp geometry: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (line_width == '0)                      lw = CW'(1);
    else if (32'(line_width) > MAX_LINE_WIDTH) lw = CW'(MAX_LINE_WIDTH);
    else                                       lw = CW'(line_width);
    if (range_looks == '0)                     rl = LK_W'(1);
    else if (32'(range_looks) > MAX_LOOKS)     rl = LK_W'(MAX_LOOKS);
    else                                       rl = LK_W'(range_looks);
    if (azimuth_looks == '0)                   al = LK_W'(1);
    else if (32'(azimuth_looks) > MAX_LOOKS)   al = LK_W'(MAX_LOOKS);
    else                                       al = LK_W'(azimuth_looks);
  end

  mlba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mlba_dp #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .MAX_LOOKS      (MAX_LOOKS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .clear          (clear),
    .cmd            (cmd),
    .status         (status),
    .lw             (lw),
    .rl             (rl),
    .al             (al),
    .complex_mode   (complex_mode),
    .power_sum      (power_sum),
    .average_enable (average_enable),
    .sample_first   (signed'(s_tdata[SAMPLE_BITS-1:0])),
    .sample_second  (signed'(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast)
  );

endmodule

@@ tb/mlba_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlba_checker
// Watches the register port and both streams of the multilook core, keeps
// its own copy of the window sums and geometry, predicts every look result
// and compares each output beat against the oldest prediction.
// ----------------------------------------------------------------------------
module mlba_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [31:0]                   s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [mlba_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [mlba_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output int                            fail_count,
  output int                            pending
);
  import mlba_pkg::*;

  localparam int MAX_LW = 4096;
  localparam int MAX_LK = 64;
  localparam longint unsigned ACC_MASK = (64'd1 << ACC_W) - 1;

  typedef struct {
    logic [RES_W-1:0] first;
    logic [RES_W-1:0] second;
    logic [CNT_W-1:0] count;
    logic             row_end;
  } look_t;

  look_t looks_due[$];

  // shadow registers
  logic [12:0] lw_reg;
  logic [6:0]  rl_reg;
  logic [6:0]  al_reg;
  logic        cplx_reg;
  logic        pow_reg;
  logic        avg_reg;

  // shadow raster state
  longint unsigned sum_a[MAX_LW];
  longint unsigned sum_b[MAX_LW];
  int              nz_cnt[MAX_LW];
  int              col;
  int              rphase;
  int              aphase;

  function automatic int clamp_geo(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void restart_raster();
    for (int i = 0; i < MAX_LW; i++) begin
      sum_a[i] = 0;
      sum_b[i] = 0;
      nz_cnt[i] = 0;
    end
    col = 0;
    rphase = 0;
    aphase = 0;
  endfunction

  // reduce one window sum: direct, rounded average or rounded root
  function automatic logic [RES_W-1:0] reduce_sum(longint unsigned acc, int n);
    longint unsigned num, lo, hi, mid, t, d, mag, q;
    longint          s;
    if (pow_reg) begin
      d = (avg_reg && n != 0) ? longint'(n) : 1;
      num = (acc & ACC_MASK) << 2;
      lo = 0;
      hi = 64'd1 << ROOT_W;
      while (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        t = 2 * mid - 1;
        if (d * t * t <= num) lo = mid;
        else hi = mid;
      end
      return lo[RES_W-1:0];
    end
    if (avg_reg && n != 0) begin
      s = longint'({{(64-ACC_W){acc[ACC_W-1]}}, acc[ACC_W-1:0]});
      mag = (s < 0) ? longint'(-s) : longint'(s);
      q = (2 * mag + n) / (2 * longint'(n));
      if (s < 0) q = -q;
      return q[RES_W-1:0];
    end
    return acc[RES_W-1:0];
  endfunction

  // advance the raster by one sample, queueing a look if a window closes
  function automatic void take_sample(logic [31:0] d);
    int     lw, rl, al, nout, oc;
    longint a, b;
    look_t  lk;
    lw = clamp_geo(lw_reg, MAX_LW);
    rl = clamp_geo(rl_reg, MAX_LK);
    al = clamp_geo(al_reg, MAX_LK);
    nout = lw / rl;
    oc = col / rl;
    a = longint'($signed(d[15:0]));
    b = cplx_reg ? longint'($signed(d[31:16])) : 0;
    if (oc < nout) begin
      if (a != 0 || b != 0) begin
        sum_a[oc] = (sum_a[oc] + (pow_reg ? a * a : a)) & ACC_MASK;
        sum_b[oc] = (sum_b[oc] + (pow_reg ? b * b : b)) & ACC_MASK;
        nz_cnt[oc] = (nz_cnt[oc] + 1) % 8192;
      end
      if (rphase + 1 >= rl && aphase + 1 >= al) begin
        lk.first = reduce_sum(sum_a[oc], nz_cnt[oc]);
        lk.second = cplx_reg ? reduce_sum(sum_b[oc], nz_cnt[oc]) : '0;
        lk.count = nz_cnt[oc];
        lk.row_end = (oc + 1 == nout);
        looks_due.push_back(lk);
        sum_a[oc] = 0;
        sum_b[oc] = 0;
        nz_cnt[oc] = 0;
      end
    end
    if (col + 1 >= lw) begin
      col = 0;
      rphase = 0;
      aphase = (aphase + 1 >= al) ? 0 : aphase + 1;
    end else begin
      col++;
      rphase = (rphase + 1 >= rl) ? 0 : rphase + 1;
    end
  endfunction

  assign pending = looks_due.size();

  // track register writes, input beats and output beats
  always @(posedge clk) begin
    look_t exp_lk;
    if (rst) begin
      lw_reg <= 13'd4096;
      rl_reg <= 7'd4;
      al_reg <= 7'd4;
      cplx_reg <= 1'b0;
      pow_reg <= 1'b0;
      avg_reg <= 1'b0;
      looks_due.delete();
      restart_raster();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_LINE_WIDTH:     lw_reg = pwdata[12:0];
          REG_RANGE_LOOKS:    rl_reg = pwdata[6:0];
          REG_AZIMUTH_LOOKS:  al_reg = pwdata[6:0];
          REG_COMPLEX_MODE:   cplx_reg = pwdata[0];
          REG_POWER_SUM:      pow_reg = pwdata[0];
          REG_AVERAGE_ENABLE: avg_reg = pwdata[0];
          default: ;
        endcase
        if (paddr[4:2] <= REG_AVERAGE_ENABLE) restart_raster();
      end
      if (s_tvalid && s_tready) take_sample(s_tdata);
      if (m_tvalid && m_tready) begin
        if (looks_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t mlba_checker: unexpected beat data=%h last=%b",
                     $realtime, m_tdata, m_tlast);
        end else begin
          exp_lk = looks_due.pop_front();
          if (m_tdata[RES_W-1:0] !== exp_lk.first ||
              m_tdata[2*RES_W-1:RES_W] !== exp_lk.second ||
              m_tdata[2*RES_W+CNT_W-1:2*RES_W] !== exp_lk.count ||
              m_tlast !== exp_lk.row_end) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t mlba_checker: mismatch exp f=%h s=%h n=%0d e=%b got f=%h s=%h n=%0d e=%b",
                       $realtime, exp_lk.first, exp_lk.second, exp_lk.count,
                       exp_lk.row_end, m_tdata[RES_W-1:0], m_tdata[2*RES_W-1:RES_W],
                       m_tdata[2*RES_W+CNT_W-1:2*RES_W], m_tlast);
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the multilook block average core: programs window geometry
// and modes over APB, streams raster samples with random idling and
// back-pressure, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import mlba_pkg::*;

  localparam int DRAIN_CYCLES = 150;
  localparam int IDLE_LIMIT   = 5000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [31:0]           s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int idle_cycles;
  int hold_left;
  int stall_left;
  bit idle_en;
  int items_sent;

  multilook_block_average_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mlba_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result-side back-pressure: a long hold-off while hold_left is set, else random bursts
  initial begin
    m_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0, 1:    return 16'h0000;
      2:       return 16'h8000;
      3:       return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_beat(input logic [15:0] a, input logic [15:0] b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, a};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) push_beat(pick_sample(), pick_sample());
  endtask

  // hold the stream until every look is out and the core has gone quiet
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_regs(input int lw, input int rl, input int al,
                              input bit cx, input bit pw, input bit av);
    drain();
    apb_write(REG_LINE_WIDTH, lw);
    apb_write(REG_RANGE_LOOKS, rl);
    apb_write(REG_AZIMUTH_LOOKS, al);
    apb_write(REG_COMPLEX_MODE, cx);
    apb_write(REG_POWER_SUM, pw);
    apb_write(REG_AVERAGE_ENABLE, av);
    @(posedge clk);
  endtask

  initial begin
    int lw, rl, al, lines;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_left = 0;
    idle_en = 1'b1;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero geometry acts as one: every sample is a look, complex plain
    program_regs(0, 0, 0, 1, 0, 0);
    push_beat(16'h8000, 16'h7fff);
    push_beat(16'h7fff, 16'h8000);
    push_beat(16'h0000, 16'h0000);
    push_beat(16'h0000, 16'h0001);
    push_beat(16'h0001, 16'h0000);
    push_beat(16'hffff, 16'hffff);
    // power without average on extreme values
    program_regs(1, 1, 1, 1, 1, 0);
    push_beat(16'h8000, 16'h8000);
    push_beat(16'h7fff, 16'h0005);
    push_beat(16'h0000, 16'h0000);
    // power with average over 2x2 windows, zeros skipped
    program_regs(4, 2, 2, 1, 1, 1);
    push_beat(16'h0003, 16'h0000);
    push_beat(16'h0000, 16'h0000);
    push_beat(16'h8000, 16'h0007);
    push_beat(16'h0000, 16'h0000);
    push_beat(16'h0004, 16'hfffd);
    push_beat(16'h0000, 16'h0000);
    push_beat(16'h7fff, 16'h8000);
    push_beat(16'h0000, 16'h0000);
    // plain average with negative ties, real only
    program_regs(4, 2, 2, 0, 0, 1);
    push_beat(16'h0003, 16'h1234);
    push_beat(16'hfffe, 16'h0000);
    push_beat(16'hfffc, 16'h0000);
    push_beat(16'h0000, 16'h0000);
    push_beat(16'h0000, 16'h5555);
    push_beat(16'h0001, 16'h0000);
    push_beat(16'hffff, 16'h0000);
    push_beat(16'h0000, 16'h0000);
    // window wider than the line never closes
    program_regs(3, 8, 1, 0, 0, 0);
    push_random(6);
    // oversized geometry clamps to the maximum line and window width
    program_regs(8191, 127, 1, 0, 1, 1);
    push_random(512);
    program_regs(1, 1, 127, 1, 0, 1);
    push_random(130);

    // fill the core with the result side held off
    program_regs(1, 1, 1, 1, 1, 1);
    hold_left = 300;
    push_random(40);

    // random geometry and modes with whole and partial windows
    while (items_sent < 1150) begin
      lw = $urandom_range(1, 40);
      rl = $urandom_range(1, 8);
      al = $urandom_range(1, 4);
      program_regs(lw, rl, al, $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1));
      lines = al * $urandom_range(1, 3) + $urandom_range(0, 1);
      push_random(lines * lw + $urandom_range(0, 3));
    end

    // closing stretch without any idling
    program_regs(12, 3, 2, 1, 0, 1);
    idle_en = 1'b0;
    push_random(120);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ multilook_block_average_core.f @@
hdl/mlba_pkg.sv
hdl/mlba_fin.sv
hdl/mlba_ctrl.sv
hdl/mlba_dp.sv
hdl/multilook_block_average_core.sv
tb/mlba_checker.sv
tb/tb_top.sv
